[sv/uer_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the echo ranger with median session.
package uer_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TRIG_LO = 3'd1,
    PH_TRIG_HI = 3'd2,
    PH_ECHO    = 3'd3,
    PH_GAP     = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_OK      = 3'd1,
    ST_RANGE   = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_SESSION = 3'd1,
    REG_TIMEOUT = 3'd2,
    REG_GAP     = 3'd3,
    REG_MIN     = 3'd4,
    REG_MAX     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MS_IDLE = 2'd0,
    MS_SCAN = 2'd1,
    MS_DONE = 2'd2
  } msel_t;

  localparam int unsigned TRIG_LO_TICKS = 2;
  localparam int unsigned TRIG_HI_TICKS = 10;
  localparam logic [11:0] DIST_SCALE = 12'd2248;

  // Request from the sequencer to the median unit and its answer.
  typedef struct packed {
    logic        go;
    logic [15:0] wr_data;
    logic        wr_en;
  } med_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] median;
  } med_rsp_t;

endpackage

[sv/uer_median.sv]
`timescale 1ns / 1ps
// Sample store and selection-based median finder.
module uer_median import uer_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     clr,
  input  med_req_t req,
  output med_rsp_t rsp,
  output logic     empty,
  output logic     busy
);
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic [15:0] mem [MAX_SAMPLES];
  logic [15:0] rd_data_r;
  logic [CW-1:0] count_r, count_nxt;

  // Selection: for each candidate i, count elements below/equal. Element at
  // rank k is the one with lt <= k < le. Walk candidates (outer) and all
  // entries (inner) through one read port: candidate fetched, then scanned.
  msel_t state_r, state_nxt;
  logic [CW-1:0] cand_r, cand_nxt, scan_r, scan_nxt;
  logic [CW-1:0] lt_r, lt_nxt, le_r, le_nxt;
  logic [15:0] cval_r, cval_nxt;
  logic        ph_r, ph_nxt;     // 0: first candidate fetch, 1: scan begun
  logic        rv_r, rv_nxt;     // read data valid (registered read)
  logic        rc_r, rc_nxt;     // pending read is the candidate fetch
  logic        got_lo_r, got_lo_nxt, got_hi_r, got_hi_nxt;
  logic [15:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] k_lo, k_hi;
  logic [AW-1:0] rd_addr;
  logic        rd_en;
  logic [16:0] sum;

  assign empty = (count_r == '0);
  assign busy  = (state_r != MS_IDLE);
  assign k_hi  = count_r >> 1;
  assign k_lo  = count_r[0] ? k_hi : k_hi - 1'b1;
  assign sum   = {1'b0, lo_r} + {1'b0, hi_r};

  always_ff @(posedge clk) begin
    if (req.wr_en && count_r < CW'(MAX_SAMPLES)) mem[count_r[AW-1:0]] <= req.wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (clr) count_nxt = '0;
    else if (req.wr_en && count_r < CW'(MAX_SAMPLES)) count_nxt = count_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MS_IDLE: if (req.go) state_nxt = MS_SCAN;
      MS_SCAN: if (got_lo_nxt && got_hi_nxt) state_nxt = MS_DONE;
      MS_DONE: state_nxt = MS_IDLE;
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_comb begin
    cand_nxt = cand_r; scan_nxt = scan_r; lt_nxt = lt_r; le_nxt = le_r;
    cval_nxt = cval_r; ph_nxt = ph_r; rv_nxt = 1'b0; rc_nxt = rc_r;
    got_lo_nxt = got_lo_r; got_hi_nxt = got_hi_r; lo_nxt = lo_r; hi_nxt = hi_r;
    rd_en = 1'b0; rd_addr = '0;
    case (state_r)
      MS_IDLE: begin
        if (req.go) begin
          cand_nxt = '0; ph_nxt = 1'b0; got_lo_nxt = 1'b0; got_hi_nxt = 1'b0;
          rd_en = 1'b1; rd_addr = '0; rv_nxt = 1'b1; rc_nxt = 1'b1;
        end
      end
      MS_SCAN: begin
        if (rv_r && rc_r) begin
          // candidate value arrived: start the scan
          cval_nxt = rd_data_r; lt_nxt = '0; le_nxt = '0; scan_nxt = '0;
          ph_nxt = 1'b1;
          rd_en = 1'b1; rd_addr = '0; rv_nxt = 1'b1; rc_nxt = 1'b0;
        end else if (rv_r) begin
          if (rd_data_r < cval_r) lt_nxt = lt_nxt + 1'b1;
          if (rd_data_r <= cval_r) le_nxt = le_nxt + 1'b1;
          if (scan_r + 1'b1 < count_r) begin
            scan_nxt = scan_r + 1'b1;
            rd_en = 1'b1; rd_addr = scan_nxt[AW-1:0]; rv_nxt = 1'b1; rc_nxt = 1'b0;
          end else begin
            if (lt_nxt <= k_lo && k_lo < le_nxt) begin
              got_lo_nxt = 1'b1; lo_nxt = cval_r;
            end
            if (lt_nxt <= k_hi && k_hi < le_nxt) begin
              got_hi_nxt = 1'b1; hi_nxt = cval_r;
            end
            if (!(got_lo_nxt && got_hi_nxt) && cand_r + 1'b1 < count_r) begin
              cand_nxt = cand_r + 1'b1;
              rd_en = 1'b1; rd_addr = cand_nxt[AW-1:0]; rv_nxt = 1'b1; rc_nxt = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      count_r <= '0;
      rv_r    <= 1'b0;
      got_lo_r <= 1'b0;
      got_hi_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rv_r    <= rv_nxt;
      got_lo_r <= got_lo_nxt;
      got_hi_r <= got_hi_nxt;
    end
    cand_r <= cand_nxt; scan_r <= scan_nxt; lt_r <= lt_nxt; le_r <= le_nxt;
    cval_r <= cval_nxt; ph_r <= ph_nxt; rc_r <= rc_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
  end

  assign rsp.done   = (state_r == MS_DONE);
  assign rsp.median = ph_r ? sum[16:1] : sum[16:1];
endmodule

[sv/ultrasonic_echo_ranger_median.sv]
`timescale 1ns / 1ps
// Echo ranger top level: tick sequencer, distance conversion, result register.
//
// Usage: each input transfer is one microsecond tick; in_tdata = {echo, start_req}.
// Every accepted tick yields exactly one result transfer on out_tdata =
// {status, distance, done_res, trigger} (21 bits packed, zero-padded to 24).
// A tick that does not end a median session has its result in the output
// register in the cycle after the input transfer; with out_tready high and
// no median search running, a new tick is accepted every cycle. A tick that
// ends a median session walks the sample memory for the median: one fetch
// plus n compare reads per candidate, at most n candidates for n stored
// samples; in_tready stays low until that result is in the output register.
// A new tick is accepted while the previous result still waits in the
// output register only if that register will be freed; in_tready is low
// while a result is held and out_tready is low, so a stalled receiver
// holds the block with no loss.
// Reset (rst_n low, synchronous) returns to idle, clears the sample count
// and loads the register reset values. No clearing pass is needed.
// Configuration writes use cfg_we/cfg_addr/cfg_wdata and take effect at once.
module ultrasonic_echo_ranger_median import uer_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] start_req, [1] echo
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] trigger, [1] done_res, [17:2] distance, [20:18] status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  logic        mode_r;
  logic [31:0] session_us_r;
  logic [15:0] timeout_us_r, min_r, max_r;
  logic [19:0] gap_us_r;

  phase_t      phase_r, phase_nxt;
  logic [19:0] pt_r, pt_nxt;
  logic [15:0] wait_r, wait_nxt, ew_r, ew_nxt;
  logic        elast_r, elast_nxt;
  logic [31:0] sess_r, sess_nxt;

  logic        ov_r;
  logic [20:0] odata_r;
  logic        medwait_r, medwait_nxt;
  logic        start, e, acc, trig;
  logic        done, want_med, wr_en, clr;
  logic [15:0] res_dist, wr_data;
  status_t     st;
  logic [27:0] prod;
  logic [17:0] dscaled;
  logic [15:0] dsat;
  logic        dvalid;
  med_req_t    mreq;
  med_rsp_t    mrsp;
  logic        mempty, mbusy;

  assign start = in_tdata[0];
  assign e     = in_tdata[1];
  assign in_tready = !medwait_r && !mbusy && (!ov_r || out_tready);
  assign acc   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; session_us_r <= 32'd1000000; timeout_us_r <= 16'd38000;
      gap_us_r <= 20'd100000; min_r <= 16'd256; max_r <= 16'd51200;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MODE:    mode_r       <= cfg_wdata[0];
        REG_SESSION: session_us_r <= cfg_wdata;
        REG_TIMEOUT: timeout_us_r <= cfg_wdata[15:0];
        REG_GAP:     gap_us_r     <= cfg_wdata[19:0];
        REG_MIN:     min_r        <= cfg_wdata[15:0];
        REG_MAX:     max_r        <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Width to distance: (w*2248)>>10, saturated at 16 bits.
  assign prod    = 28'(ew_r) * 28'(DIST_SCALE);
  assign dscaled = prod[27:10];
  assign dsat    = (dscaled > 18'd65535) ? 16'hFFFF : dscaled[15:0];
  assign dvalid  = (dsat >= min_r) && (dsat <= max_r);

  // Tick sequencer: next state.
  always_comb begin
    logic    fell, meas_end, check, egt;
    status_t mst;
    logic [15:0] mdist;
    phase_nxt = phase_r; pt_nxt = pt_r; wait_nxt = wait_r; ew_nxt = ew_r;
    elast_nxt = elast_r; sess_nxt = sess_r;
    trig = 1'b0; done = 1'b0; res_dist = '0; st = ST_NONE; want_med = 1'b0;
    wr_en = 1'b0; wr_data = '0; clr = 1'b0;
    fell = 1'b0; meas_end = 1'b0; check = 1'b0; egt = 1'b0;
    mst = ST_NONE; mdist = '0;
    if (phase_r != PH_IDLE && sess_r != 32'hFFFFFFFF) sess_nxt = sess_r + 1'b1;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          sess_nxt = '0; clr = 1'b1;
          if (mode_r && session_us_r == '0) begin
            done = 1'b1; st = ST_EMPTY;
          end else begin
            phase_nxt = PH_TRIG_LO; pt_nxt = 20'd1;
          end
        end
      end
      PH_TRIG_LO: begin
        pt_nxt = pt_r + 1'b1;
        if (pt_nxt >= 20'(TRIG_LO_TICKS)) begin
          phase_nxt = PH_TRIG_HI; pt_nxt = '0;
        end
      end
      PH_TRIG_HI: begin
        trig = 1'b1;
        pt_nxt = pt_r + 1'b1;
        if (pt_nxt >= 20'(TRIG_HI_TICKS)) begin
          phase_nxt = PH_ECHO; pt_nxt = '0; wait_nxt = '0; ew_nxt = '0; elast_nxt = 1'b0;
        end
      end
      PH_ECHO: begin
        if (wait_r != 16'hFFFF) wait_nxt = wait_r + 1'b1;
        if (e && !elast_r) ew_nxt = 16'd1;
        else if (e && elast_r) begin
          if (ew_r != 16'hFFFF) ew_nxt = ew_r + 1'b1;
        end else if (!e && elast_r) fell = 1'b1;
        elast_nxt = e;
        if (fell) begin
          meas_end = 1'b1;
          mst = dvalid ? ST_OK : ST_RANGE;
          mdist = dvalid ? dsat : '0;
        end else if (wait_nxt >= timeout_us_r) begin
          meas_end = 1'b1; mst = ST_TIMEOUT;
        end
        if (meas_end) begin
          if (!mode_r) begin
            done = 1'b1; st = mst; res_dist = mdist; phase_nxt = PH_IDLE;
          end else begin
            if (mst == ST_OK) begin
              wr_en = 1'b1; wr_data = mdist;
            end
            if (gap_us_r == '0) check = 1'b1;
            else begin
              phase_nxt = PH_GAP; pt_nxt = '0;
            end
          end
        end
      end
      PH_GAP: begin
        pt_nxt = pt_r + 1'b1;
        if (pt_nxt >= gap_us_r) check = 1'b1;
      end
      default: phase_nxt = PH_IDLE;
    endcase
    if (check) begin
      if (sess_nxt < session_us_r) begin
        phase_nxt = PH_TRIG_LO; pt_nxt = 20'd1;
      end else begin
        phase_nxt = PH_IDLE; done = 1'b1;
        // empty check counts the write on this tick
        egt = mempty && !wr_en;
        if (egt) st = ST_EMPTY;
        else begin
          st = ST_OK; want_med = 1'b1;
        end
      end
    end
  end

  assign mreq.wr_en   = acc && wr_en;
  assign mreq.wr_data = wr_data;
  assign mreq.go      = medwait_r && !mbusy && !mrsp.done && !ov_r;

  assign medwait_nxt = medwait_r ? !mrsp.done : (acc && want_med);

  uer_median #(.MAX_SAMPLES(MAX_SAMPLES)) u_median (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (acc && clr),
    .req   (mreq),
    .rsp   (mrsp),
    .empty (mempty),
    .busy  (mbusy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; pt_r <= '0; wait_r <= '0; ew_r <= '0;
      elast_r <= 1'b0; sess_r <= '0; ov_r <= 1'b0; medwait_r <= 1'b0;
    end else begin
      medwait_r <= medwait_nxt;
      if (acc) begin
        phase_r <= phase_nxt; pt_r <= pt_nxt; wait_r <= wait_nxt; ew_r <= ew_nxt;
        elast_r <= elast_nxt; sess_r <= sess_nxt;
      end
      if (acc && !want_med) ov_r <= 1'b1;
      else if (mrsp.done) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    if (acc) odata_r <= {st, res_dist, done, trig};
    else if (mrsp.done) odata_r <= {ST_OK, mrsp.median, 1'b1, 1'b0};
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'b000, odata_r};
endmodule

[sv/uer_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the echo ranger, bound to the top level.
module uer_checker import uer_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  // Distance is zero unless status is ok.
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20:18] != ST_OK |-> out_tdata[17:2] == 16'd0)
    else $error("distance nonzero without ok status");
  // A nonzero status only comes with done.
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20:18] != ST_NONE |-> out_tdata[1])
    else $error("status without done");
  // Trigger and done never coincide.
  a_trig_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("trigger on done tick");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  // No input transfer while a result is stalled.
  a_no_in_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(in_tvalid && in_tready))
    else $error("input transfer while result stalled");
endmodule

bind ultrasonic_echo_ranger_median uer_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
